FILE: rtl/hsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsd_pkg
// Shared constants, types and helpers for the extended Hamming SECDED decoder.
// ----------------------------------------------------------------------------
package hsd_pkg;

  localparam int DATA_BYTES_DEF = 4;   // default data bytes per codeword
  localparam int DATA_W         = 32;  // width of the data result
  localparam int BYTES_W        = 3;   // width of the byte-count field
  localparam int STATUS_W       = 2;   // width of the status result
  localparam int SYN_W          = 6;   // syndrome / position width (positions <= 63)

  typedef enum logic [STATUS_W-1:0] {
    STAT_CLEAN  = 2'd0,  // no error
    STAT_FIXED  = 2'd1,  // single error corrected (or overall parity bit alone)
    STAT_DOUBLE = 2'd2,  // double error detected
    STAT_RANGE  = 2'd3   // odd parity with syndrome at or past the code length
  } status_e;

  // Check result handed from the syndrome stage to the correction stage
  typedef struct packed {
    logic [SYN_W-1:0]   syn;
    logic               par;
    logic [BYTES_W-1:0] bytes;
  } chk_t;

  // Code length n (overall parity position) for a byte count
  function automatic int code_len(input int bytes);
    int mbits;
    int r;
    mbits = 8 * bytes;
    r     = 1;
    for (int i = 0; i < 7; i++) begin
      if ((1 << r) < mbits + r + 1) begin
        r = r + 1;
      end
    end
    return mbits + r + 1;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/hsd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsd_in_if / hsd_out_if
// Valid/ready channels for codewords in and decoded data out.
// ----------------------------------------------------------------------------
interface hsd_in_if
  import hsd_pkg::*;
#(
  parameter int CW_W = code_len(DATA_BYTES_DEF)
);
  logic               valid;
  logic               ready;
  logic [CW_W-1:0]    codeword;
  logic [BYTES_W-1:0] word_bytes;

  modport source (output valid, output codeword, output word_bytes, input ready);
  modport sink   (input valid, input codeword, input word_bytes, output ready);
endinterface

interface hsd_out_if
  import hsd_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   data;
  logic [STATUS_W-1:0] status;

  modport source (output valid, output data, output status, input ready);
  modport sink   (input valid, input data, input status, output ready);
endinterface
`default_nettype wire

FILE: rtl/hsd_mask.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsd_mask
// Stage 1: clamps the byte count, trims the word to its code length and
// splits off the overall parity bit.
// ----------------------------------------------------------------------------
module hsd_mask
  import hsd_pkg::*;
#(
  parameter int  DATA_BYTES = DATA_BYTES_DEF,
  localparam int CW_W       = code_len(DATA_BYTES)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  hsd_in_if.sink                  in_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output logic [CW_W-2:0]         word_o,
  output logic                    pbit_o,
  output logic [BYTES_W-1:0]      bytes_o
);

  logic [BYTES_W-1:0] bytes_c;
  logic [SYN_W-1:0]   len_c;
  logic [CW_W-2:0]    word_c;
  logic               pbit_c;
  logic               en;

  logic               valid_q;
  logic [CW_W-2:0]    word_q;
  logic               pbit_q;
  logic [BYTES_W-1:0] bytes_q;

  always_comb begin
    if (in_i.word_bytes == '0) begin
      bytes_c = BYTES_W'(1);
    end else if (in_i.word_bytes > BYTES_W'(DATA_BYTES)) begin
      bytes_c = BYTES_W'(DATA_BYTES);
    end else begin
      bytes_c = in_i.word_bytes;
    end
    len_c = SYN_W'(code_len(int'(bytes_c)));
  end

  // keep positions 1..n-1; position n is the overall parity bit
  always_comb begin
    pbit_c = 1'b0;
    for (int i = 0; i < CW_W - 1; i++) begin
      word_c[i] = in_i.codeword[i] & (i < int'(len_c) - 1);
    end
    for (int i = 0; i < CW_W; i++) begin
      pbit_c = pbit_c | (in_i.codeword[i] & (i == int'(len_c) - 1));
    end
  end

  assign en        = !valid_q || ready_i;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_i.valid) begin
      word_q  <= word_c;
      pbit_q  <= pbit_c;
      bytes_q <= bytes_c;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;
  assign pbit_o  = pbit_q;
  assign bytes_o = bytes_q;

endmodule
`default_nettype wire

FILE: rtl/hsd_syndrome.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsd_syndrome
// Stage 2: XOR tree of set positions (syndrome) and overall parity.
// ----------------------------------------------------------------------------
module hsd_syndrome
  import hsd_pkg::*;
#(
  parameter int  DATA_BYTES = DATA_BYTES_DEF,
  localparam int CW_W       = code_len(DATA_BYTES)
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire logic [CW_W-2:0]    word_i,
  input  wire logic               pbit_i,
  input  wire logic [BYTES_W-1:0] bytes_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output logic [CW_W-2:0]         word_o,
  output chk_t                    chk_o
);

  logic [SYN_W-1:0] syn_c;
  logic             en;

  logic             valid_q;
  logic [CW_W-2:0]  word_q;
  chk_t             chk_q;

  always_comb begin
    syn_c = '0;
    for (int i = 0; i < CW_W - 1; i++) begin
      if (word_i[i]) begin
        syn_c = syn_c ^ SYN_W'(i + 1);
      end
    end
  end

  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      word_q      <= word_i;
      chk_q.syn   <= syn_c;
      chk_q.par   <= (^word_i) ^ pbit_i;
      chk_q.bytes <= bytes_i;
    end
  end

  assign valid_o = valid_q;
  assign word_o  = word_q;
  assign chk_o   = chk_q;

  // a stalled stage keeps its check result
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ready_i) |=> (valid_q && $stable(chk_q) && $stable(word_q)))
    else $error("syndrome stage lost data under stall");

endmodule
`default_nettype wire

FILE: rtl/hsd_correct.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsd_correct
// Stage 3: classify and flip the erroneous bit.
// Stage 4: pack data bits in position order; this is the output register.
// ----------------------------------------------------------------------------
module hsd_correct
  import hsd_pkg::*;
#(
  parameter int  DATA_BYTES = DATA_BYTES_DEF,
  localparam int CW_W       = code_len(DATA_BYTES)
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            valid_i,
  output logic                 ready_o,
  input  wire logic [CW_W-2:0] word_i,
  input  wire chk_t            chk_i,
  hsd_out_if.source            out_o
);

  // stage 3
  logic [SYN_W-1:0]   len_c;
  logic               fix_c;
  status_e            status_c;
  logic [CW_W-2:0]    word_fix_c;
  logic               en3;
  logic               valid3_q;
  logic [CW_W-2:0]    word3_q;
  status_e            status3_q;
  logic [BYTES_W-1:0] bytes3_q;

  // stage 4
  logic [DATA_W-1:0]  raw_c;
  logic [DATA_W-1:0]  data_c;
  logic               en4;
  logic               valid4_q;
  logic [DATA_W-1:0]  data4_q;
  status_e            status4_q;

  always_comb begin
    len_c = SYN_W'(code_len(int'(chk_i.bytes)));
    fix_c = 1'b0;
    if (!chk_i.par) begin
      status_c = (chk_i.syn == '0) ? STAT_CLEAN : STAT_DOUBLE;
    end else if (chk_i.syn == '0) begin
      status_c = STAT_FIXED;              // overall parity bit alone
    end else if (chk_i.syn < len_c) begin
      status_c = STAT_FIXED;
      fix_c    = 1'b1;
    end else begin
      status_c = STAT_RANGE;
    end
    for (int i = 0; i < CW_W - 1; i++) begin
      word_fix_c[i] = word_i[i] ^ (fix_c && (chk_i.syn == SYN_W'(i + 1)));
    end
  end

  assign en3     = !valid3_q || en4;
  assign ready_o = en3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid3_q <= 1'b0;
    end else if (en3) begin
      valid3_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && valid_i) begin
      word3_q   <= word_fix_c;
      status3_q <= status_c;
      bytes3_q  <= chk_i.bytes;
    end
  end

  // data bits sit at the non-power-of-two positions
  always_comb begin
    int k;
    k     = 0;
    raw_c = '0;
    for (int pos = 1; pos < CW_W; pos++) begin
      if ((pos & (pos - 1)) != 0) begin
        if (k < DATA_W) begin
          raw_c[k] = word3_q[pos-1];
        end
        k = k + 1;
      end
    end
    for (int j = 0; j < DATA_W; j++) begin
      data_c[j] = raw_c[j] & (j < 8 * int'(bytes3_q));
    end
  end

  assign en4 = !valid4_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid4_q <= 1'b0;
    end else if (en4) begin
      valid4_q <= valid3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en4 && valid3_q) begin
      data4_q   <= data_c;
      status4_q <= status3_q;
    end
  end

  assign out_o.valid  = valid4_q;
  assign out_o.data   = data4_q;
  assign out_o.status = status4_q;

  a_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && ready_o) |=> valid3_q)
    else $error("accepted transaction not captured in correction stage");

  a_double: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && ready_o && !chk_i.par && chk_i.syn != '0) |=> (status3_q == STAT_DOUBLE))
    else $error("even parity with nonzero syndrome not flagged as double error");

  a_stall3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid3_q && !en4) |=> (valid3_q && $stable(word3_q) && $stable(status3_q)))
    else $error("correction stage changed while stalled");

endmodule
`default_nettype wire

FILE: rtl/hamming_secded_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hamming_secded_decoder
// Extended Hamming SECDED decoder: one codeword of 1..DATA_BYTES data bytes
// per transaction, corrected data and status per transaction.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Payload                         | Handshake
//  --------+-----+---------------------------------+-------------------
//  in_i    | in  | codeword[CW_W-1:0], word_bytes  | valid & ready
//  out_o   | out | data[31:0], status[1:0]         | valid & ready
//
//  Four register stages (mask, syndrome, correct, pack). The first captures
//  at the accepting edge; the data then passes the syndrome and correct
//  registers in order, and output valid rises when the pack register takes
//  it. One transaction per cycle: each stage takes a new one whenever it is
//  empty or its downstream stage is ready.
//  Reset clears only the stage valid bits; payload registers are not reset.
//  Ready ripples back through the stages, so an empty stage still fills while
//  the output is stalled; a stalled stage holds its contents.
//
//  Status: 0 clean, 1 single error corrected (or overall parity bit alone),
//  2 double error, 3 odd parity with syndrome at or past the code length.
//  Data on status 2 and 3 is the uncorrected data.
// ----------------------------------------------------------------------------
module hamming_secded_decoder
  import hsd_pkg::*;
#(
  parameter int DATA_BYTES = DATA_BYTES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hsd_in_if.sink    in_i,
  hsd_out_if.source out_o
);

  localparam int CW_W = code_len(DATA_BYTES);

  // stage 1 -> stage 2: trimmed word without the parity bit
  logic               m_valid;
  logic               m_ready;
  logic [CW_W-2:0]    m_word;
  logic               m_pbit;
  logic [BYTES_W-1:0] m_bytes;

  // stage 2 -> stage 3: word plus syndrome, parity, byte count
  logic               s_valid;
  logic               s_ready;
  logic [CW_W-2:0]    s_word;
  chk_t               s_chk;

  hsd_mask #(
    .DATA_BYTES (DATA_BYTES)
  ) u_mask (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .valid_o (m_valid),
    .ready_i (m_ready),
    .word_o  (m_word),
    .pbit_o  (m_pbit),
    .bytes_o (m_bytes)
  );

  hsd_syndrome #(
    .DATA_BYTES (DATA_BYTES)
  ) u_syndrome (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (m_valid),
    .ready_o (m_ready),
    .word_i  (m_word),
    .pbit_i  (m_pbit),
    .bytes_i (m_bytes),
    .valid_o (s_valid),
    .ready_i (s_ready),
    .word_o  (s_word),
    .chk_o   (s_chk)
  );

  hsd_correct #(
    .DATA_BYTES (DATA_BYTES)
  ) u_correct (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_valid),
    .ready_o (s_ready),
    .word_i  (s_word),
    .chk_i   (s_chk),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire
